// ===== hdl/msfd_pkg.sv =====
package msfd_pkg;

  localparam int unsigned HeadW = 64;
  localparam int unsigned TailW = 24;
  localparam int unsigned FlagW = 15;

  localparam int unsigned FlAogValid = 0;
  localparam int unsigned FlOnGround = 1;
  localparam int unsigned FlSquawk   = 2;
  localparam int unsigned FlAltitude = 3;
  localparam int unsigned FlStatus   = 4;
  localparam int unsigned FlCallsign = 5;
  localparam int unsigned FlVrate    = 6;
  localparam int unsigned FlEw       = 7;
  localparam int unsigned FlNs       = 8;
  localparam int unsigned FlSpeed    = 9;
  localparam int unsigned FlHeading  = 10;
  localparam int unsigned FlCprOdd   = 11;
  localparam int unsigned FlCprEven  = 12;
  localparam int unsigned FlMetres   = 13;

  localparam logic [4:0] Df0  = 5'd0;
  localparam logic [4:0] Df4  = 5'd4;
  localparam logic [4:0] Df5  = 5'd5;
  localparam logic [4:0] Df11 = 5'd11;
  localparam logic [4:0] Df16 = 5'd16;
  localparam logic [4:0] Df17 = 5'd17;
  localparam logic [4:0] Df18 = 5'd18;
  localparam logic [4:0] Df20 = 5'd20;
  localparam logic [4:0] Df21 = 5'd21;

  localparam logic [12:0] IdMask    = 13'h1FFF;
  localparam logic [12:0] MetreBit  = 13'h0040;
  localparam logic [12:0] HighMask  = 13'h1F80;
  localparam logic [15:0] Ty23Mask  = 16'hFFF1;
  localparam logic [7:0]  SigSat    = 8'd255;
  localparam int          AltOffset = 1000;

  // Altitude source selection carried from stage 1 to stage 2.
  typedef enum logic [1:0] {
    ALT_NONE,
    ALT_Q25,
    ALT_GILLHAM
  } alt_src_e;

  // Stage 1 -> stage 2 word.
  typedef struct packed {
    logic [14:0] flags;
    logic [7:0]  sig;
    logic [2:0]  resp;
    logic [7:0]  sq;
    alt_src_e    alt_src;
    logic [10:0] alt_n;
    logic [12:0] alt_id;
    logic [12:0] sqk_id;
    logic        sqk_en;
    logic [47:0] call_bits;
    logic        call_en;
    logic [11:0] speed;
    logic [6:0]  mv;
    logic        mv_en;
    logic [9:0]  hdg_raw;
    logic [1:0]  hdg_mode;
    logic [15:0] vrate;
    logic [12:0] ew;
    logic [12:0] ns;
    logic [33:0] cpr;
  } s1_t;

  // Stage 2 -> stage 3 word.
  typedef struct packed {
    logic [14:0] flags;
    logic [7:0]  sig;
    logic [2:0]  resp;
    logic [7:0]  sq;
    alt_src_e    alt_src;
    logic [10:0] alt_n;
    logic [6:0]  g_five;
    logic [2:0]  g_one;
    logic        g_bad;
    logic [14:0] squawk;
    logic [63:0] call;
    logic [11:0] speed;
    logic [8:0]  heading;
    logic [15:0] vrate;
    logic [12:0] ew;
    logic [12:0] ns;
    logic [33:0] cpr;
  } s2_t;

  localparam logic [1:0] HdgNone = 2'd0;
  localparam logic [1:0] HdgAir  = 2'd1;
  localparam logic [1:0] HdgSurf = 2'd2;

  function automatic logic [14:0] id13_to_hex(input logic [12:0] f);
    logic [14:0] h;
    h = '0;
    h[4]  = f[12];
    h[12] = f[11];
    h[5]  = f[10];
    h[13] = f[9];
    h[6]  = f[8];
    h[14] = f[7];
    h[8]  = f[5];
    h[0]  = f[4];
    h[9]  = f[3];
    h[1]  = f[2];
    h[10] = f[1];
    h[2]  = f[0];
    return h;
  endfunction

  function automatic logic [7:0] six_bit_char(input logic [5:0] c);
    logic [7:0] r;
    if (c >= 6'd1 && c <= 6'd26) r = 8'h40 + {2'b0, c};
    else if (c == 6'd32) r = 8'h20;
    else if (c >= 6'd48 && c <= 6'd57) r = {2'b0, c};
    else r = 8'h3F;
    return r;
  endfunction

  function automatic logic [11:0] movement_knots(input logic [6:0] m);
    logic [11:0] r;
    if (m > 7'd123) r = 12'd199;
    else if (m > 7'd108) r = 12'({m - 7'd108, 2'b0} + {5'b0, m - 7'd108}) + 12'd100;
    else if (m > 7'd93) r = 12'({m - 7'd93, 1'b0}) + 12'd70;
    else if (m > 7'd38) r = 12'(m - 7'd38) + 12'd15;
    else if (m > 7'd12) r = 12'((m - 7'd11) >> 1) + 12'd2;
    else if (m > 7'd8) r = 12'((m - 7'd6) >> 2) + 12'd1;
    else r = 12'd0;
    return r;
  endfunction

endpackage

// ===== hdl/msfd_extract.sv =====
module msfd_extract
  import msfd_pkg::*;
(
  input  logic [63:0] head_i,
  input  logic [23:0] tail_i,
  input  logic [4:0]  df_i,
  input  logic [31:0] sum_i,
  output s1_t         word_o
);

  logic [7:0] b0, b4, b5, b6, b7, b8, b9, b10;
  logic [2:0] ca;
  logic [12:0] id;
  logic [4:0] ty;
  logic [2:0] sub;
  logic es;
  logic [9:0] vr, ewr, nsr, as;
  logic [11:0] f12;
  logic [15:0] w;
  logic [12:0] fsq;

  always_comb begin
    b0 = head_i[63:56];
    b4 = head_i[31:24];
    b5 = head_i[23:16];
    b6 = head_i[15:8];
    b7 = head_i[7:0];
    b8 = tail_i[23:16];
    b9 = tail_i[15:8];
    b10 = tail_i[7:0];
    ca = b0[2:0];
    id = head_i[44:32] & IdMask;
    ty = b4[7:3];
    sub = (ty == 5'd29) ? {1'b0, b4[2:1]} : b4[2:0];
    es = (df_i == Df17) || (df_i == Df18 && (ca == 3'd0 || ca == 3'd1 || ca == 3'd6));
    vr = {1'b0, b8[2:0], b9[7:2]};
    ewr = {b5[1:0], b6};
    nsr = {b7[6:0], b8[7:5]};
    as = nsr;
    f12 = {b5, b6[7:4]};
    w = {b5, b6};
    fsq = '0;

    word_o = '0;
    word_o.sig = (sum_i[31:12] > 20'd255) ? SigSat : sum_i[19:12];
    word_o.alt_src = ALT_NONE;
    word_o.hdg_mode = HdgNone;
    word_o.call_bits = {head_i[23:0], tail_i};

    if (df_i == Df11 || df_i == Df17 || df_i == Df18) word_o.resp = ca;
    if (df_i == Df0 || df_i == Df16) begin
      word_o.flags[FlAogValid] = 1'b1;
      word_o.flags[FlOnGround] = b0[2];
    end
    if (df_i == Df11 || df_i == Df17) begin
      if (ca == 3'd4) begin
        word_o.flags[FlAogValid] = 1'b1;
        word_o.flags[FlOnGround] = 1'b1;
      end else if (ca == 3'd5) begin
        word_o.flags[FlAogValid] = 1'b1;
      end
    end
    if ((df_i == Df5 || df_i == Df21) && id != '0 && (id & MetreBit) == '0) begin
      word_o.sqk_en = 1'b1;
      word_o.sqk_id = id;
    end
    if ((df_i == Df0 || df_i == Df4 || df_i == Df16 || df_i == Df20) && id != '0) begin
      word_o.flags[FlAltitude] = 1'b1;
      if (id[6]) begin
        word_o.flags[FlMetres] = 1'b1;
      end else if (id[4]) begin
        word_o.alt_src = ALT_Q25;
        word_o.alt_n = 11'((id & HighMask) >> 2) | {6'b0, id[5], id[3:0]};
      end else begin
        word_o.alt_src = ALT_GILLHAM;
        word_o.alt_id = id;
      end
    end
    if (df_i == Df4 || df_i == Df5 || df_i == Df20 || df_i == Df21) begin
      word_o.flags[FlStatus] = 1'b1;
      word_o.resp = ca;
      if (ca <= 3'd3) begin
        word_o.flags[FlAogValid] = 1'b1;
        if (ca[0]) word_o.flags[FlOnGround] = 1'b1;
      end
    end
    if (es) begin
      word_o.sq = {ty, sub};
      if (ty >= 5'd1 && ty <= 5'd4) begin
        word_o.flags[FlCallsign] = 1'b1;
        word_o.call_en = 1'b1;
      end else if (ty == 5'd19) begin
        word_o.flags[FlAogValid] = 1'b1;
        if (sub >= 3'd1 && sub <= 3'd4 && vr != '0) begin
          word_o.vrate = b8[3] ? 16'(-(int'(vr - 10'd1) * 64)) : 16'({vr - 10'd1, 6'b0});
          word_o.flags[FlVrate] = 1'b1;
        end
        if (sub == 3'd1 || sub == 3'd2) begin
          if (ewr != '0) begin
            word_o.flags[FlEw] = 1'b1;
            word_o.ew = 13'({3'b0, ewr - 10'd1} << ((sub == 3'd2) ? 2 : 0));
            if (b5[2]) word_o.ew = -word_o.ew;
          end
          if (nsr != '0) begin
            word_o.flags[FlNs] = 1'b1;
            word_o.ns = 13'({3'b0, nsr - 10'd1} << ((sub == 3'd2) ? 2 : 0));
            if (b7[7]) word_o.ns = -word_o.ns;
          end
        end else if (sub == 3'd3 || sub == 3'd4) begin
          if (as != '0) begin
            word_o.flags[FlSpeed] = 1'b1;
            word_o.speed = 12'({2'b0, as - 10'd1} << ((sub == 3'd4) ? 2 : 0));
          end
          if (b5[2]) begin
            word_o.flags[FlHeading] = 1'b1;
            word_o.hdg_mode = HdgAir;
            word_o.hdg_raw = ewr;
          end
        end
      end else if (ty >= 5'd5 && ty <= 5'd22) begin
        word_o.cpr = {b6[1:0], b7, b8[7:1], b8[0], b9, b10};
        word_o.flags[FlCprOdd] = b6[2];
        word_o.flags[FlCprEven] = !b6[2];
        word_o.flags[FlAogValid] = 1'b1;
        if (ty >= 5'd9) begin
          if (f12 != '0) begin
            word_o.flags[FlAltitude] = 1'b1;
            if (f12[4]) begin
              word_o.alt_src = ALT_Q25;
              word_o.alt_n = {f12[11:5], f12[3:0]};
            end else begin
              word_o.alt_src = ALT_GILLHAM;
              word_o.alt_id = {f12[11:6], 1'b0, f12[5:0]};
            end
          end
        end else begin
          word_o.flags[FlOnGround] = 1'b1;
          word_o.mv = {b4[2:0], b5[7:4]};
          if (word_o.mv != '0 && word_o.mv < 7'd125) begin
            word_o.flags[FlSpeed] = 1'b1;
            word_o.mv_en = 1'b1;
          end
          if (b5[3]) begin
            word_o.flags[FlHeading] = 1'b1;
            word_o.hdg_mode = HdgSurf;
            word_o.hdg_raw = {3'b0, f12[6:0]};
          end
        end
      end else if (ty == 5'd23 || ty == 5'd28) begin
        if (ty == 5'd23 && sub == 3'd7) fsq = 13'((w & Ty23Mask) >> 3);
        if (ty == 5'd28 && sub == 3'd1) fsq = w[12:0];
        if (fsq != '0 && !fsq[6]) begin
          word_o.sqk_en = 1'b1;
          word_o.sqk_id = fsq;
        end
      end
    end
    if ((df_i == Df20 || df_i == Df21) && b4 == 8'h20) begin
      word_o.flags[FlCallsign] = 1'b1;
      word_o.call_en = 1'b1;
    end
    word_o.flags[FlSquawk] = word_o.sqk_en;
  end

endmodule

// ===== hdl/msfd_convert.sv =====
module msfd_convert
  import msfd_pkg::*;
(
  input  s1_t word_i,
  output s2_t word_o
);

  logic [14:0] a;
  logic [2:0] one;
  logic [6:0] five;
  logic [19:0] hprod;
  integer i;

  always_comb begin
    word_o = '0;
    word_o.flags = word_i.flags;
    word_o.sig = word_i.sig;
    word_o.resp = word_i.resp;
    word_o.sq = word_i.sq;
    word_o.alt_src = word_i.alt_src;
    word_o.alt_n = word_i.alt_n;
    word_o.vrate = word_i.vrate;
    word_o.ew = word_i.ew;
    word_o.ns = word_i.ns;
    word_o.cpr = word_i.cpr;
    word_o.squawk = word_i.sqk_en ? id13_to_hex(word_i.sqk_id) : '0;
    if (word_i.call_en) begin
      for (i = 0; i < 8; i++) begin
        word_o.call[63 - 8 * i -: 8] = six_bit_char(word_i.call_bits[47 - 6 * i -: 6]);
      end
    end
    word_o.speed = word_i.mv_en ? movement_knots(word_i.mv) : word_i.speed;
    hprod = 20'(word_i.hdg_raw) * 20'd45;
    case (word_i.hdg_mode)
      HdgAir:  word_o.heading = hprod[15:7];
      HdgSurf: word_o.heading = hprod[12:4];
      default: word_o.heading = '0;
    endcase

    // Gillham: C bits make the hundreds digit, A/B/D bits the 500 ft count.
    // D1 and D2 make the code illegal, so they never reach the count.
    a = id13_to_hex(word_i.alt_id);
    one = '0;
    five = '0;
    if (a[4]) one = one ^ 3'd7;
    if (a[5]) one = one ^ 3'd3;
    if (a[6]) one = one ^ 3'd1;
    if ((one & 3'd5) == 3'd5) one = one ^ 3'd2;
    if (a[2]) five = five ^ 7'h7F;
    if (a[12]) five = five ^ 7'h3F;
    if (a[13]) five = five ^ 7'h1F;
    if (a[14]) five = five ^ 7'h0F;
    if (a[8]) five = five ^ 7'h07;
    if (a[9]) five = five ^ 7'h03;
    if (a[10]) five = five ^ 7'h01;
    word_o.g_bad = (a[0] | a[1] | a[3] | a[7] | a[11]) || a[6:4] == '0 || one > 3'd5;
    if (five[0]) one = 3'd6 - one;
    word_o.g_five = five;
    word_o.g_one = one;
  end

endmodule

// ===== hdl/mode_s_field_decoder.sv =====
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_ready  | message head/tail, downlink format, signal sum
// out     | source    | out_valid/out_ready| flags, level and decoded fields
//
// Three register stages: extract fields, convert codes (identity, charset,
// movement, heading, Gillham digits), then altitude scaling into the output
// register. One word per cycle while the output is not stalled. Reset
// clears the stage valid bits only. A stalled output holds every stage that
// is full; a stage advances whenever the stage after it is empty or moving.
module mode_s_field_decoder
  import msfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        message_head_i,
  input  logic [23:0]        message_tail_i,
  input  logic [4:0]         downlink_format_i,
  input  logic [31:0]        signal_sum_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        valid_flags_o,
  output logic [7:0]         signal_level_o,
  output logic [2:0]         responder_code_o,
  output logic [7:0]         squitter_code_o,
  output logic signed [17:0] altitude_feet_o,
  output logic [14:0]        squawk_code_o,
  output logic [63:0]        callsign_text_o,
  output logic [11:0]        speed_knots_o,
  output logic [8:0]         heading_degrees_o,
  output logic signed [15:0] vertical_rate_o,
  output logic [25:0]        velocity_pair_o,
  output logic [33:0]        cpr_position_o
);

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic signed [17:0] alt_d, alt_q;
  logic signed [10:0] hundreds;
  s2_t s3_q;

  // Advance a stage when the stage ahead of it can take its word.
  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  msfd_extract u_extract (
    .head_i (message_head_i),
    .tail_i (message_tail_i),
    .df_i   (downlink_format_i),
    .sum_i  (signal_sum_i),
    .word_o (s1_d)
  );

  msfd_convert u_convert (
    .word_i (s1_q),
    .word_o (s2_d)
  );

  // Final altitude: 25 ft steps or Gillham hundreds times 100.
  always_comb begin
    hundreds = 11'(signed'({4'b0, s2_q.g_five}) * 5) + 11'(signed'({8'b0, s2_q.g_one}))
               - 11'sd13;
    case (s2_q.alt_src)
      ALT_Q25: alt_d = 18'(signed'({7'b0, s2_q.alt_n}) * 25) - 18'(AltOffset);
      ALT_GILLHAM: begin
        if (s2_q.g_bad || hundreds < -11'sd12) alt_d = '0;
        else alt_d = 18'(hundreds * 100);
      end
      default: alt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
    if (adv3 && v2_q) begin
      s3_q <= s2_q;
      alt_q <= alt_d;
    end
  end

  assign out_valid_o = v3_q;
  assign valid_flags_o = s3_q.flags;
  assign signal_level_o = s3_q.sig;
  assign responder_code_o = s3_q.resp;
  assign squitter_code_o = s3_q.sq;
  assign altitude_feet_o = alt_q;
  assign squawk_code_o = s3_q.squawk;
  assign callsign_text_o = s3_q.call;
  assign speed_knots_o = s3_q.speed;
  assign heading_degrees_o = s3_q.heading;
  assign vertical_rate_o = s3_q.vrate;
  assign velocity_pair_o = {s3_q.ew, s3_q.ns};
  assign cpr_position_o = s3_q.cpr;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_flags_o))
    else $error("output word changed under stall");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !v3_q |=> v3_q)
    else $error("stage 2 word not advanced into empty output");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !valid_flags_o[14])
    else $error("reserved flag set");
  a_cpr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(valid_flags_o[FlCprOdd] && valid_flags_o[FlCprEven]))
    else $error("both CPR flags set");

endmodule
